/* design/acb_pkg.sv */
// ----------------------------------------------------------------------------
// acb_pkg
// Shared codes, constants and control/status types of the ALU execute block.
// ----------------------------------------------------------------------------
package acb_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 5;
  localparam int unsigned CondW  = 2;
  localparam int unsigned CwW    = 2;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW   = $clog2(DivSteps);

  // stream payload widths (fields padded to whole bytes)
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 136;

  // operation codes
  localparam logic [KindW-1:0] K_MOV  = 5'd0;
  localparam logic [KindW-1:0] K_ADD  = 5'd1;
  localparam logic [KindW-1:0] K_SUB  = 5'd2;
  localparam logic [KindW-1:0] K_MUL  = 5'd3;
  localparam logic [KindW-1:0] K_DIV  = 5'd4;
  localparam logic [KindW-1:0] K_CMP  = 5'd5;
  localparam logic [KindW-1:0] K_SHL  = 5'd6;
  localparam logic [KindW-1:0] K_SHR  = 5'd7;
  localparam logic [KindW-1:0] K_SAR  = 5'd8;
  localparam logic [KindW-1:0] K_AND  = 5'd9;
  localparam logic [KindW-1:0] K_OR   = 5'd10;
  localparam logic [KindW-1:0] K_XOR  = 5'd11;
  localparam logic [KindW-1:0] K_SWAP = 5'd12;
  localparam logic [KindW-1:0] K_LDL  = 5'd13;
  localparam logic [KindW-1:0] K_LDH  = 5'd14;
  localparam logic [KindW-1:0] K_NOT  = 5'd15;
  localparam logic [KindW-1:0] K_JMP  = 5'd16;
  localparam logic [KindW-1:0] K_JZ   = 5'd17;
  localparam logic [KindW-1:0] K_JP   = 5'd18;
  localparam logic [KindW-1:0] K_JN   = 5'd19;
  localparam logic [KindW-1:0] K_JNZ  = 5'd20;
  localparam logic [KindW-1:0] K_JNP  = 5'd21;
  localparam logic [KindW-1:0] K_JNN  = 5'd22;

  // condition codes
  localparam logic [CondW-1:0] COND_ZERO = 2'd0;
  localparam logic [CondW-1:0] COND_POS  = 2'd1;
  localparam logic [CondW-1:0] COND_NEG  = 2'd2;

  // compare widths
  localparam logic [CwW-1:0] CW_HALF = 2'd1;
  localparam logic [CwW-1:0] CW_BYTE = 2'd2;

  localparam logic [DataW-1:0] SEG_MASK = 32'hFFFF0000;
  localparam logic [DataW-1:0] OFS_MASK = 32'h0000FFFF;

  typedef struct packed {
    logic load;        // capture request operands
    logic mul_en;      // register the product
    logic div_start;   // seed the divider
    logic div_step;    // one quotient bit
    logic finish;      // write output register and condition
  } acb_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic out_free;    // output register empty or being drained
  } acb_sts_t;

endpackage

/* design/acb_ctrl.sv */
// ----------------------------------------------------------------------------
// acb_ctrl
// Sequencer: accept, dispatch, multiply or divide iterations, write-back.
// ----------------------------------------------------------------------------
module acb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  acb_pkg::acb_sts_t sts_i,
  output acb_pkg::acb_cmd_t cmd_o
);
  import acb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  state_e          state_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          cnt_q <= '0;
          if (sts_i.is_mul) begin
            state_q <= S_MUL;
          end else if (sts_i.is_div && !sts_i.div_zero) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MUL: state_q <= S_DONE;
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) state_q <= S_DONE;
        end
        S_DONE: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_valid_i && (state_q == S_IDLE);
    cmd_o.div_start = (state_q == S_DISPATCH) && sts_i.is_div && !sts_i.div_zero;
    cmd_o.mul_en    = (state_q == S_MUL);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.finish    = (state_q == S_DONE) && sts_i.out_free;
  end

`ifndef SYNTHESIS
  // write-back never overruns a held result
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free)
    else $error("finish issued while output register busy");

  // a divide runs all its steps before write-back
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != CntLast) |=> (state_q == S_DIV))
    else $error("divide left early");

  // after a write-back the block is ready for the next request
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> in_ready_o)
    else $error("not ready after finish");
`endif

endmodule

/* design/acb_dpath.sv */
// ----------------------------------------------------------------------------
// acb_dpath
// Operand registers, ALU, registered multiplier, radix-2 divider,
// condition register and output register.
// ----------------------------------------------------------------------------
module acb_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  acb_pkg::acb_cmd_t             cmd_i,
  output acb_pkg::acb_sts_t             sts_o,
  input  logic [acb_pkg::KindW-1:0]     in_kind_i,
  input  logic [acb_pkg::InDataW-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acb_pkg::OutDataW-1:0]  out_data_o
);
  import acb_pkg::*;

  function automatic logic [CondW-1:0] cond_of(input logic [DataW-1:0] v);
    logic [CondW-1:0] c;
    if (v == '0) c = COND_ZERO;
    else if (v[DataW-1]) c = COND_NEG;
    else c = COND_POS;
    return c;
  endfunction

  // operand registers
  logic [KindW-1:0] kind_q;
  logic [DataW-1:0] a_q, b_q, ip_q;
  logic [CwW-1:0]   cw_q;

  // multiplier / divider
  logic [DataW-1:0] prod_q;
  logic [DataW-1:0] quo_q, rem_q, mb_q;
  logic [DataW-1:0] ma, mb;
  logic [DataW:0]   rem_sh, trial;
  logic             ge;

  // condition and output registers
  logic [CondW-1:0] cond_q, cond_d;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // ALU results
  logic [DataW-1:0] res, swp, rem, q_s, r_s, x, y, diff, cval, np, shl, shr, sar;
  logic             dw, sw, rw, flt, setc, taken, big;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind_i;
      a_q    <= in_data_i[31:0];
      b_q    <= in_data_i[63:32];
      cw_q   <= in_data_i[65:64];
      ip_q   <= in_data_i[97:66];
    end
    if (cmd_i.mul_en) prod_q <= a_q * b_q;
    if (cmd_i.div_start) begin
      quo_q <= ma;
      rem_q <= '0;
      mb_q  <= mb;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DataW-2:0], ge};
      rem_q <= ge ? trial[DataW-1:0] : rem_sh[DataW-1:0];
    end
  end

  assign ma     = a_q[DataW-1] ? (DataW'(0) - a_q) : a_q;
  assign mb     = b_q[DataW-1] ? (DataW'(0) - b_q) : b_q;
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign trial  = rem_sh - {1'b0, mb_q};
  assign ge     = !trial[DataW];

  assign q_s = (a_q[DataW-1] ^ b_q[DataW-1]) ? (DataW'(0) - quo_q) : quo_q;
  assign r_s = a_q[DataW-1] ? (DataW'(0) - rem_q) : rem_q;

  // shifts: counts of 32 or more flush out or sign fill
  assign big = |b_q[DataW-1:5];
  assign shl = big ? '0 : (a_q << b_q[4:0]);
  assign shr = big ? '0 : (a_q >> b_q[4:0]);
  assign sar = big ? {DataW{a_q[DataW-1]}} : DataW'($signed(a_q) >>> b_q[4:0]);

  always_comb begin
    case (cw_q)
      CW_HALF: begin
        x = {{16{a_q[15]}}, a_q[15:0]};
        y = {{16{b_q[15]}}, b_q[15:0]};
      end
      CW_BYTE: begin
        x = {{24{a_q[7]}}, a_q[7:0]};
        y = {{24{b_q[7]}}, b_q[7:0]};
      end
      default: begin
        x = a_q;
        y = b_q;
      end
    endcase
  end
  assign diff = x - y;

  always_comb begin
    res = '0; swp = '0; rem = '0;
    dw = 1'b0; sw = 1'b0; rw = 1'b0; flt = 1'b0; setc = 1'b0; taken = 1'b0;
    case (kind_q)
      K_MOV:  begin res = b_q; dw = 1'b1; end
      K_ADD:  begin res = a_q + b_q; dw = 1'b1; setc = 1'b1; end
      K_SUB:  begin res = a_q - b_q; dw = 1'b1; setc = 1'b1; end
      K_MUL:  begin res = prod_q; dw = 1'b1; setc = 1'b1; end
      K_DIV:  begin
        if (b_q == '0) begin
          flt = 1'b1;
        end else begin
          res = q_s; rem = r_s; dw = 1'b1; rw = 1'b1; setc = 1'b1;
        end
      end
      K_CMP:  setc = 1'b1;
      K_SHL:  begin res = shl; dw = 1'b1; setc = 1'b1; end
      K_SHR:  begin res = shr; dw = 1'b1; setc = 1'b1; end
      K_SAR:  begin res = sar; dw = 1'b1; setc = 1'b1; end
      K_AND:  begin res = a_q & b_q; dw = 1'b1; setc = 1'b1; end
      K_OR:   begin res = a_q | b_q; dw = 1'b1; setc = 1'b1; end
      K_XOR:  begin res = a_q ^ b_q; dw = 1'b1; setc = 1'b1; end
      K_SWAP: begin res = b_q; swp = a_q; dw = 1'b1; sw = 1'b1; end
      K_LDL:  begin res = (a_q & SEG_MASK) | (b_q & OFS_MASK); dw = 1'b1; end
      K_LDH:  begin res = {b_q[15:0], a_q[15:0]}; dw = 1'b1; end
      K_NOT:  begin res = ~a_q; dw = 1'b1; setc = 1'b1; end
      K_JMP:  taken = 1'b1;
      K_JZ:   taken = (cond_q == COND_ZERO);
      K_JP:   taken = (cond_q == COND_POS);
      K_JN:   taken = (cond_q == COND_NEG);
      K_JNZ:  taken = (cond_q != COND_ZERO);
      K_JNP:  taken = (cond_q != COND_POS);
      K_JNN:  taken = (cond_q != COND_NEG);
      default: ;
    endcase
  end

  assign cval   = (kind_q == K_CMP) ? diff : res;
  assign cond_d = setc ? cond_of(cval) : cond_q;
  assign np     = taken ? ((ip_q & SEG_MASK) | (b_q & OFS_MASK)) : ip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q      <= COND_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        cond_q      <= cond_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= {1'b0, taken, np, flt, cond_d, rw, rem, sw, dw, swp, res};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.is_mul   = (kind_q == K_MUL);
  assign sts_o.is_div   = (kind_q == K_DIV);
  assign sts_o.div_zero = (b_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  // a division fault writes nothing back
  a_fault_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[101]) |-> (!out_data_q[64] && !out_data_q[98]))
    else $error("write enable set on division fault");

  // jumps never touch the condition
  a_jump_keeps_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && kind_q >= K_JMP) |=> (cond_q == $past(cond_q)))
    else $error("condition changed by a jump");
`endif

endmodule

/* design/alu_with_condition_and_branch.sv */
// ----------------------------------------------------------------------------
// alu_with_condition_and_branch
// Execute stage of a small virtual machine with a kept sign/zero condition.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is taken only when the block is
// idle; it then passes through a dispatch state, the work itself and a
// write-back state that writes the output register. Multiply uses one
// registered 32x32 product; divide uses the radix-2 restoring divider that
// retires one quotient bit per cycle. Divide by zero skips the divider and
// raises fault. The block is ready again the cycle after write-back, so it
// takes no new request before it is through with the last one. A finished
// result sits in the output register while the next request is accepted
// and worked on; only the final write waits for the register to drain.
// The condition (zero/positive/negative) updates at write-back, so a jump
// always sees the condition left by the request before.
// ----------------------------------------------------------------------------
module alu_with_condition_and_branch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata, from bit 0: first_operand[31:0], second_operand[63:32],
  //   compare_width[65:64], instruction_pointer[97:66], zero pad [103:98]
  input  logic [acb_pkg::InDataW-1:0]    s_axis_tdata_i,
  // tuser: kind[4:0]
  input  logic [acb_pkg::KindW-1:0]      s_axis_tuser_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata, from bit 0: result[31:0], swapped_value[63:32], dest_write[64],
  //   source_write[65], remainder[97:66], remainder_write[98],
  //   condition_out[100:99], fault[101], next_pointer[133:102],
  //   branch_taken[134], zero pad [135]
  output logic [acb_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import acb_pkg::*;

  acb_cmd_t cmd;
  acb_sts_t sts;

  acb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the ALU execute block with kept condition and jumps.
// ----------------------------------------------------------------------------
// Requests come from a queue that an initial block fills. The directed part
// goes first, then random instructions. A clocked driver sends them and a
// clocked monitor takes the results. Each accepted request runs through a
// local model of the datapath and its condition. The modeled write-back is
// queued and compared field by field with the next result. Both sides idle
// at random in two of three phases. The receiver also holds off once for a long
// stretch, so that the block backs up.
// ----------------------------------------------------------------------------
module tb;
  import acb_pkg::*;

  localparam int unsigned NumRandom  = 1150;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned DrainWait  = 40;
  localparam logic [DataW-1:0] MinInt = 32'h8000_0000;
  localparam logic [DataW-1:0] MaxInt = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] dst_val;
    logic [DataW-1:0] src_val;
    logic [CwW-1:0]   cmp_w;
    logic [DataW-1:0] ip;
  } instr_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [DataW-1:0] swapped;
    logic             dest_we;
    logic             src_we;
    logic [DataW-1:0] rem;
    logic             rem_we;
    logic [CondW-1:0] cond;
    logic             fault;
    logic [DataW-1:0] next_ip;
    logic             taken;
  } writeback_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic [KindW-1:0]    s_kind = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  instr_t     instr_queue[$];
  writeback_t predicted_wb[$];
  instr_t     cur_instr = '0;
  logic [CondW-1:0] cond_q = COND_ZERO;

  int unsigned dispatched = 0;
  int unsigned accepted = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned divides = 0;
  int unsigned jumps_taken = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  alu_with_condition_and_branch dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // phase 0: sender idles 15%, receiver 47%; phase 1 swapped; phase 2 none
  function automatic int idle_phase();
    int unsigned total;
    total = NumRandom + 32;
    if (dispatched < total / 3) return 0;
    if (dispatched < 2 * total / 3) return 1;
    return 2;
  endfunction

  function automatic logic roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Datapath model: updates the kept condition and returns the write-back
  function automatic writeback_t exec_instruction(instr_t in);
    writeback_t w;
    logic [DataW-1:0] a, b, x, y, ma, mb, q, r, diff;
    logic set_cond;
    w = '0;
    a = in.dst_val;
    b = in.src_val;
    diff = '0;
    set_cond = 1'b0;
    case (in.kind)
      K_MOV: begin w.result = b; w.dest_we = 1'b1; end
      K_ADD: begin w.result = a + b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_SUB: begin w.result = a - b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_MUL: begin w.result = a * b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_DIV: begin
        if (b == '0) begin
          w.fault = 1'b1;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          r = ma % mb;
          w.result = (a[31] != b[31]) ? -q : q;
          w.rem = a[31] ? -r : r;
          w.dest_we = 1'b1;
          w.rem_we = 1'b1;
          set_cond = 1'b1;
        end
      end
      K_CMP: begin
        x = a;
        y = b;
        if (in.cmp_w == CW_HALF) begin
          x = {{16{a[15]}}, a[15:0]};
          y = {{16{b[15]}}, b[15:0]};
        end else if (in.cmp_w == CW_BYTE) begin
          x = {{24{a[7]}}, a[7:0]};
          y = {{24{b[7]}}, b[7:0]};
        end
        diff = x - y;
        set_cond = 1'b1;
      end
      K_SHL: begin
        w.result = (b >= 32) ? '0 : a << b[4:0];
        w.dest_we = 1'b1;
        set_cond = 1'b1;
      end
      K_SHR: begin
        w.result = (b >= 32) ? '0 : a >> b[4:0];
        w.dest_we = 1'b1;
        set_cond = 1'b1;
      end
      K_SAR: begin
        w.result = (b >= 32) ? {DataW{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
        w.dest_we = 1'b1;
        set_cond = 1'b1;
      end
      K_AND: begin w.result = a & b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_OR:  begin w.result = a | b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_XOR: begin w.result = a ^ b; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_SWAP: begin
        w.result = b;
        w.swapped = a;
        w.dest_we = 1'b1;
        w.src_we = 1'b1;
      end
      K_LDL: begin w.result = (a & SEG_MASK) | (b & OFS_MASK); w.dest_we = 1'b1; end
      K_LDH: begin w.result = (a & OFS_MASK) | ((b & OFS_MASK) << 16); w.dest_we = 1'b1; end
      K_NOT: begin w.result = ~a; w.dest_we = 1'b1; set_cond = 1'b1; end
      K_JMP: w.taken = 1'b1;
      K_JZ:  w.taken = (cond_q == COND_ZERO);
      K_JP:  w.taken = (cond_q == COND_POS);
      K_JN:  w.taken = (cond_q == COND_NEG);
      K_JNZ: w.taken = (cond_q != COND_ZERO);
      K_JNP: w.taken = (cond_q != COND_POS);
      K_JNN: w.taken = (cond_q != COND_NEG);
      default: ;
    endcase
    if (set_cond) begin
      if (in.kind != K_CMP) diff = w.result;
      if (diff == '0) cond_q = COND_ZERO;
      else if (diff[31]) cond_q = COND_NEG;
      else cond_q = COND_POS;
    end
    w.cond = cond_q;
    w.next_ip = w.taken ? ((in.ip & SEG_MASK) | (b & OFS_MASK)) : in.ip;
    return w;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return MinInt;
      4: return MaxInt;
      5: return $urandom_range(0, 300);
      6: return -$urandom_range(1, 300);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_instr(logic [KindW-1:0] k, logic [DataW-1:0] a,
                           logic [DataW-1:0] b, logic [CwW-1:0] cw);
    instr_t it;
    it.kind = k;
    it.dst_val = a;
    it.src_val = b;
    it.cmp_w = cw;
    it.ip = $urandom;
    instr_queue.push_back(it);
  endtask

  task automatic check_field(string name, logic [DataW-1:0] exp_v,
                             logic [DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Driver: counts the request taken at this edge, then offers the next one
  always @(posedge clk_i) begin : drive_requests
    writeback_t wb;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        wb = exec_instruction(cur_instr);
        predicted_wb.push_back(wb);
        accepted++;
        if (cur_instr.kind == K_DIV) divides++;
        if (wb.taken) jumps_taken++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (instr_queue.size() != 0 &&
            !((idle_phase() == 0 && roll(15)) || (idle_phase() == 1 && roll(47)))) begin
          cur_instr <= instr_queue[0];
          s_data <= {6'b0, instr_queue[0].ip, instr_queue[0].cmp_w,
                     instr_queue[0].src_val, instr_queue[0].dst_val};
          s_kind <= instr_queue[0].kind;
          s_valid <= 1'b1;
          void'(instr_queue.pop_front());
          dispatched++;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest modeled write-back
  always @(posedge clk_i) begin : take_results
    writeback_t act, exp_wb;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        act.result  = m_axis_tdata_o[31:0];
        act.swapped = m_axis_tdata_o[63:32];
        act.dest_we = m_axis_tdata_o[64];
        act.src_we  = m_axis_tdata_o[65];
        act.rem     = m_axis_tdata_o[97:66];
        act.rem_we  = m_axis_tdata_o[98];
        act.cond    = m_axis_tdata_o[100:99];
        act.fault   = m_axis_tdata_o[101];
        act.next_ip = m_axis_tdata_o[133:102];
        act.taken   = m_axis_tdata_o[134];
        if (predicted_wb.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %h",
                   $time, m_axis_tdata_o);
          mismatches++;
        end else begin
          exp_wb = predicted_wb.pop_front();
          check_field("result", exp_wb.result, act.result);
          check_field("swapped_value", exp_wb.swapped, act.swapped);
          check_field("dest_write", DataW'(exp_wb.dest_we), DataW'(act.dest_we));
          check_field("source_write", DataW'(exp_wb.src_we), DataW'(act.src_we));
          check_field("remainder", exp_wb.rem, act.rem);
          check_field("remainder_write", DataW'(exp_wb.rem_we), DataW'(act.rem_we));
          check_field("condition_out", DataW'(exp_wb.cond), DataW'(act.cond));
          check_field("fault", DataW'(exp_wb.fault), DataW'(act.fault));
          check_field("next_pointer", exp_wb.next_ip, act.next_ip);
          check_field("branch_taken", DataW'(exp_wb.taken), DataW'(act.taken));
        end
        checked++;
      end
      // one long hold-off so the block backs up and drops tready
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_ready <= 1'b0;
      end else if (!hold_done && checked >= HoldAfter) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        m_ready <= 1'b0;
      end else begin
        m_ready <= !((idle_phase() == 0 && roll(47)) || (idle_phase() == 1 && roll(15)));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout, %0d results still awaited", $time, predicted_wb.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    instr_t it;
    // directed: extremes, every operation, special cases
    add_instr(K_MOV, '0, MinInt, '0);
    add_instr(K_ADD, MaxInt, 32'd1, '0);          // wraps negative
    add_instr(K_JN, $urandom, $urandom, '0);
    add_instr(K_JNN, $urandom, $urandom, '0);
    add_instr(K_SUB, 32'd5, 32'd5, '0);
    add_instr(K_JZ, $urandom, $urandom, '0);
    add_instr(K_JNZ, $urandom, $urandom, '0);
    add_instr(K_MUL, MaxInt, MaxInt, '0);
    add_instr(K_JP, $urandom, $urandom, '0);
    add_instr(K_JNP, $urandom, $urandom, '0);
    add_instr(K_DIV, -32'd7, 32'd2, '0);          // negative remainder
    add_instr(K_DIV, $urandom, '0, '0);           // divide by zero
    add_instr(K_DIV, MinInt, '1, '0);             // quotient overflow
    add_instr(K_CMP, MinInt, 32'd1, '0);          // difference wraps
    add_instr(K_CMP, 32'h0001_8000, 32'h0000_0001, CW_HALF);
    add_instr(K_CMP, 32'h0000_007F, 32'h0000_FF80, CW_BYTE);
    add_instr(K_CMP, 32'h1234_5678, 32'h1234_5678, 2'd3);
    add_instr(K_SHL, 32'd1, 32'd32, '0);
    add_instr(K_SHR, '1, 32'd31, '0);
    add_instr(K_SAR, MinInt, '1, '0);             // negative count: sign fill
    add_instr(K_AND, '1, MinInt, '0);
    add_instr(K_OR, '0, '0, '0);
    add_instr(K_XOR, MaxInt, '1, '0);
    add_instr(K_SWAP, MaxInt, MinInt, '0);
    add_instr(K_LDL, '1, '0, '0);
    add_instr(K_LDH, '0, '1, '0);
    add_instr(K_NOT, '0, $urandom, '0);
    add_instr(K_JMP, $urandom, '1, '0);
    add_instr('1, '1, '1, 2'd3);                  // unknown kind

    for (int n = 0; n < NumRandom; n++) begin
      it.kind = roll(4) ? KindW'($urandom_range(23, 31)) : KindW'($urandom_range(0, 22));
      it.dst_val = pick_operand();
      it.src_val = pick_operand();
      if ((it.kind == K_SHL || it.kind == K_SHR || it.kind == K_SAR) && roll(70))
        it.src_val = $urandom_range(0, 40);
      if (it.kind == K_DIV && roll(40)) it.src_val = $urandom_range(1, 20);
      if (it.kind == K_CMP && roll(25))
        it.src_val = (it.dst_val & OFS_MASK) | ($urandom & SEG_MASK);
      it.cmp_w = CwW'($urandom_range(0, 3));
      it.ip = $urandom;
      instr_queue.push_back(it);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (instr_queue.size() != 0 || s_valid) @(posedge clk_i);
    while (predicted_wb.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d requests (%0d divides, %0d taken jumps) through three idle phases",
             accepted, divides, jumps_taken);
    $display("and one long output stall; %0d results compared, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
